// ===== src/tea_block_cipher_unit_defines.svh =====
// Assertion macros for the TEA block cipher unit.
// Included by the top level; no other dependencies.
`ifndef TEA_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define TEA_BLOCK_CIPHER_UNIT_DEFINES_SVH

// same-cycle implication
`define TEA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tea assertion failed: label");

// next-cycle implication
`define TEA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tea assertion failed: label");

`endif

// ===== src/tea_pkg.sv =====
// Shared types, constants and round functions of the TEA block cipher unit.
// No dependencies.
`default_nettype none

package tea_pkg;

    localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

    localparam logic [31:0] KEY0_RESET = 32'd1337;
    localparam logic [31:0] KEY1_RESET = 32'd2674;
    localparam logic [31:0] KEY2_RESET = 32'd5348;
    localparam logic [31:0] KEY3_RESET = 32'd10696;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3 = 3'd3;

    localparam logic ACT_ENCIPHER = 1'b0;
    localparam logic ACT_DECIPHER = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
    } t_blk;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_key;

    function automatic logic [31:0] tea_mix(input logic [31:0] v, input logic [31:0] s,
                                            input logic [31:0] ka, input logic [31:0] kb);
        tea_mix = ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
    endfunction

    function automatic logic [31:0] tea_sum(input logic [31:0] n);
        logic [63:0] prod;
        prod    = 64'(TEA_DELTA) * 64'(n);
        tea_sum = prod[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/tea_half_round.sv =====
// One half round of TEA as a register stage: updates one word of the block.
// Depends on tea_pkg.
`default_nettype none

module tea_half_round
    import tea_pkg::*;
#(
    parameter logic [31:0] ENC_SUM = 32'h9E37_79B9,
    parameter logic [31:0] DEC_SUM = 32'hC6EF_3720,
    parameter bit          HALF    = 1'b0
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_blk i_blk,
    input  wire t_key i_key,
    output logic      o_valid,
    output t_blk      o_blk
);

    logic        r_valid;
    t_blk        r_blk;
    t_blk        n_blk;
    logic        upd_y;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] sum;
    logic [31:0] mixv;
    logic [31:0] res;

    always_comb begin
        upd_y = (i_blk.action == HALF);
        src   = upd_y ? i_blk.z : i_blk.y;
        dst   = upd_y ? i_blk.y : i_blk.z;
        ka    = upd_y ? i_key.a : i_key.c;
        kb    = upd_y ? i_key.b : i_key.d;
        sum   = (i_blk.action == ACT_DECIPHER) ? DEC_SUM : ENC_SUM;
        mixv  = tea_mix(src, sum, ka, kb);
        res   = (i_blk.action == ACT_DECIPHER) ? (dst - mixv) : (dst + mixv);
        n_blk = i_blk;
        if (upd_y) begin
            n_blk.y = res;
        end else begin
            n_blk.z = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_blk <= n_blk;
        end
    end

    assign o_valid = r_valid;
    assign o_blk   = r_blk;

endmodule

`default_nettype wire

// ===== src/tea_out_skid.sv =====
// Output register with a skid entry; parts the pipeline from the receiver.
// Depends on tea_pkg.
`default_nettype none

module tea_out_skid
    import tea_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_blk i_blk,
    input  wire logic i_stall,
    output logic      o_ready,
    output logic      o_skid_valid,
    output logic      o_valid,
    output t_blk      o_blk
);

    logic r_out_valid;
    logic r_skid_valid;
    t_blk r_out;
    t_blk r_skid;
    logic take;
    logic room;
    logic push;

    assign take = r_out_valid & ~i_stall;
    assign room = take | ~r_out_valid;
    assign push = ~r_skid_valid & i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid && room) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else if (push) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= ~room;
        end else if (take) begin
            r_out_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid && room) begin
            r_out <= r_skid;
        end else if (push && room) begin
            r_out <= i_blk;
        end else if (push) begin
            r_skid <= i_blk;
        end
    end

    assign o_ready      = ~r_skid_valid;
    assign o_skid_valid = r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_blk        = r_out;

endmodule

`default_nettype wire

// ===== src/tea_block_cipher_unit.sv =====
// TEA block cipher unit: key registers, half-round pipeline and output skid.
// Depends on tea_pkg, tea_half_round, tea_out_skid and the defines header.
//
// Usage: a request on the input channel (i_valid/o_stall) carries one
// 64-bit block as i_first_word/i_second_word, the i_action bit (0 encipher,
// 1 decipher) and i_last_block. Each request gives one result on the output
// channel (o_valid/i_stall), in order, with o_out_last copying the flag.
// The key is four 32-bit words written through i_cfg_we/i_cfg_index/
// i_cfg_data; index past the last key word is ignored. Write keys only
// while no request is in flight.
// Each accepted block passes one register stage per half round plus the
// output register. Throughput: one block per cycle while the pipeline is not frozen.
// Reset (synchronous, active low) empties the pipeline and loads the
// default key 1337, 2674, 5348, 10696.
// When the receiver stalls, the result holds in the output register; the
// next finished block lands in the skid entry, and only then does the
// pipeline freeze and o_stall rise.
`default_nettype none
`include "tea_block_cipher_unit_defines.svh"

module tea_block_cipher_unit
    import tea_pkg::*;
#(
    parameter int ROUNDS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_action,
    input  wire logic [31:0]          i_first_word,
    input  wire logic [31:0]          i_second_word,
    input  wire logic                 i_last_block,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [31:0]               o_out_first_word,
    output logic [31:0]               o_out_second_word,
    output logic                      o_out_last,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);

    localparam int NSTAGE = 2 * ROUNDS;

    t_key            r_key;
    logic [NSTAGE:0] w_valid;
    t_blk            w_blk [0:NSTAGE];
    logic            pipe_en;
    logic            skid_valid;
    t_blk            out_blk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key.a <= KEY0_RESET;
            r_key.b <= KEY1_RESET;
            r_key.c <= KEY2_RESET;
            r_key.d <= KEY3_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY0: r_key.a <= i_cfg_data;
                CFG_KEY1: r_key.b <= i_cfg_data;
                CFG_KEY2: r_key.c <= i_cfg_data;
                CFG_KEY3: r_key.d <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_valid[0]      = i_valid;
    assign w_blk[0].action = i_action;
    assign w_blk[0].y      = i_first_word;
    assign w_blk[0].z      = i_second_word;
    assign w_blk[0].last   = i_last_block;

    for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
        localparam int          RND     = k / 2;
        localparam logic [31:0] ENC_SUM = tea_sum(32'(RND + 1));
        localparam logic [31:0] DEC_SUM = tea_sum(32'(ROUNDS - RND));
        tea_half_round #(
            .ENC_SUM (ENC_SUM),
            .DEC_SUM (DEC_SUM),
            .HALF    ((k % 2) == 1)
        ) u_half (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pipe_en),
            .i_valid (w_valid[k]),
            .i_blk   (w_blk[k]),
            .i_key   (r_key),
            .o_valid (w_valid[k+1]),
            .o_blk   (w_blk[k+1])
        );
    end

    tea_out_skid u_skid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_valid[NSTAGE]),
        .i_blk        (w_blk[NSTAGE]),
        .i_stall      (i_stall),
        .o_ready      (pipe_en),
        .o_skid_valid (skid_valid),
        .o_valid      (o_valid),
        .o_blk        (out_blk)
    );

    assign o_stall           = ~pipe_en;
    assign o_out_first_word  = out_blk.y;
    assign o_out_second_word = out_blk.z;
    assign o_out_last        = out_blk.last;

    `TEA_ASSERT_NOW(a_skid_needs_out, i_clk, i_rst_n, skid_valid, o_valid)
    `TEA_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, skid_valid && !i_stall, !skid_valid)
    `TEA_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_valid && !o_stall, w_valid[1])
    `TEA_ASSERT_NEXT(a_pipe_frozen, i_clk, i_rst_n, skid_valid, $stable(w_valid[NSTAGE:1]))

endmodule

`default_nettype wire
